/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the NAND ID geometry decoder.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge out of reset.
`define NIDG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define NIDG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define NIDG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/nidg_pkg.sv */
// Shared types and constants of the NAND ID geometry decoder.
// No dependencies; imported by nidg_decode, nand_id_geometry_decoder and the testbench.
package nidg_pkg;

    // Decode rule sets selected by the format register
    typedef enum logic [2:0] {
        FMT_TRAD   = 3'd0,
        FMT_H      = 3'd1,
        FMT_HB     = 3'd2,
        FMT_HB_BG  = 3'd3,
        FMT_HC_AG  = 3'd4,
        FMT_NEWSTY = 3'd5
    } t_fmt;

    localparam int CAP_W   = 17;
    localparam int BASE_W  = 14;
    localparam int CE_W    = 4;
    localparam int BLOCK_W = 25;
    localparam int PAGE_W  = 15;
    localparam int SPARE_W = 10;
    localparam int ECC_W   = 6;
    localparam int CHUNK_W = 12;
    localparam int PLANE_W = 4;

    localparam logic [CAP_W-1:0] CAP_MAX = 17'd65536;

    // One item of ID bytes
    typedef struct packed {
        logic [7:0] plane_ecc_byte;
        logic [7:0] geometry_byte;
        logic [7:0] cell_byte;
        logic [7:0] device_code;
    } t_id;

    // Decoded geometry, before capacity scaling
    typedef struct packed {
        logic [BASE_W-1:0]  base_mb;
        logic               ce_bypass;
        logic [BLOCK_W-1:0] block_bytes;
        logic [PAGE_W-1:0]  page_bytes;
        logic [SPARE_W-1:0] spare_bytes;
        logic [ECC_W-1:0]   ecc_strength;
        logic [CHUNK_W-1:0] ecc_chunk_bytes;
        logic [PLANE_W-1:0] plane_count;
    } t_geom;

endpackage

/* hw/rtl/nidg_decode.sv */
// Combinational ID byte decode: device table lookup and geometry rule sets.
// Depends on nidg_pkg.
module nidg_decode (
    input  nidg_pkg::t_fmt  i_fmt,
    input  nidg_pkg::t_id   i_id,
    output nidg_pkg::t_geom o_geom
);
    import nidg_pkg::*;

    // Device code to capacity in MB, 0 on a miss
    function automatic logic [BASE_W-1:0] dev_mb(input logic [7:0] code);
        logic [BASE_W-1:0] mb;
        unique case (code)
            8'hf0:   mb = 14'd64;
            8'hd1:   mb = 14'd128;
            8'hf1:   mb = 14'd128;
            8'hda:   mb = 14'd256;
            8'hdc:   mb = 14'd512;
            8'hd3:   mb = 14'd1024;
            8'hd5:   mb = 14'd2048;
            8'hd7:   mb = 14'd4096;
            8'hd9:   mb = 14'd8192;
            default: mb = '0;
        endcase
        return mb;
    endfunction

    function automatic logic [11:0] blk_kb_h(input logic [1:0] idx);
        logic [11:0] kb;
        case (idx)
            2'd0:    kb = 12'd128;
            2'd1:    kb = 12'd256;
            2'd2:    kb = 12'd512;
            default: kb = 12'd768;
        endcase
        return kb;
    endfunction

    function automatic logic [11:0] blk_kb_hb(input logic [2:0] idx);
        logic [11:0] kb;
        case (idx)
            3'd1:    kb = 12'd256;
            3'd2:    kb = 12'd512;
            3'd3:    kb = 12'd768;
            3'd4:    kb = 12'd1024;
            3'd5:    kb = 12'd2048;
            default: kb = 12'd128;
        endcase
        return kb;
    endfunction

    function automatic logic [SPARE_W-1:0] spare_h(input logic [2:0] idx);
        return (idx == 3'd1) ? 10'd224 : 10'd128;
    endfunction

    function automatic logic [SPARE_W-1:0] spare_hb(input logic [2:0] idx);
        logic [SPARE_W-1:0] s;
        case (idx)
            3'd1:    s = 10'd224;
            3'd2:    s = 10'd448;
            default: s = 10'd128;
        endcase
        return s;
    endfunction

    function automatic logic [SPARE_W-1:0] spare_bg(input logic [2:0] idx);
        logic [SPARE_W-1:0] s;
        case (idx)
            3'd1:    s = 10'd224;
            3'd2:    s = 10'd448;
            3'd3:    s = 10'd64;
            3'd4:    s = 10'd32;
            3'd5:    s = 10'd16;
            3'd6:    s = 10'd640;
            default: s = 10'd128;
        endcase
        return s;
    endfunction

    // 0 marks codes that fall back to 16 bytes per 512
    function automatic logic [SPARE_W-1:0] spare_new(input logic [2:0] idx);
        logic [SPARE_W-1:0] s;
        case (idx)
            3'd1:    s = 10'd128;
            3'd2:    s = 10'd218;
            3'd3:    s = 10'd400;
            3'd4:    s = 10'd436;
            3'd5:    s = 10'd512;
            3'd6:    s = 10'd640;
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [ECC_W-1:0] ecc_h(input logic [2:0] idx);
        logic [ECC_W-1:0] e;
        case (idx)
            3'd1:    e = 6'd2;
            3'd2:    e = 6'd4;
            3'd3:    e = 6'd8;
            3'd4:    e = 6'd12;
            3'd5:    e = 6'd16;
            default: e = 6'd1;
        endcase
        return e;
    endfunction

    function automatic logic [ECC_W-1:0] ecc_hb(input logic [2:0] idx);
        logic [ECC_W-1:0] e;
        case (idx) inside
            3'd0:         e = 6'd1;
            3'd1:         e = 6'd2;
            3'd2:         e = 6'd4;
            3'd3:         e = 6'd8;
            3'd4:         e = 6'd16;
            default:      e = 6'd24;
        endcase
        return e;
    endfunction

    function automatic logic [ECC_W-1:0] ecc_bg(input logic [2:0] idx);
        logic [ECC_W-1:0] e;
        case (idx) inside
            3'd0, 3'd1: e = 6'd1;
            3'd2:       e = 6'd2;
            3'd3:       e = 6'd4;
            3'd4:       e = 6'd8;
            3'd5:       e = 6'd40;
            3'd6:       e = 6'd32;
            default:    e = 6'd24;
        endcase
        return e;
    endfunction

    function automatic logic [ECC_W-1:0] ecc_ag(input logic [2:0] idx);
        logic [ECC_W-1:0] e;
        case (idx) inside
            3'd0, 3'd1: e = 6'd1;
            3'd2:       e = 6'd2;
            3'd3:       e = 6'd4;
            3'd4:       e = 6'd8;
            3'd5:       e = 6'd24;
            3'd6:       e = 6'd32;
            default:    e = 6'd40;
        endcase
        return e;
    endfunction

    function automatic logic [CHUNK_W-1:0] chunk_hb(input logic [2:0] idx);
        logic [CHUNK_W-1:0] c;
        case (idx) inside
            3'd5:       c = 12'd2048;
            3'd6, 3'd7: c = 12'd1024;
            default:    c = 12'd512;
        endcase
        return c;
    endfunction

    logic [7:0]         w_g;
    logic [7:0]         w_p;
    logic [2:0]         w_ecode;
    logic [2:0]         w_redt;
    logic [2:0]         w_blk3;
    logic [1:0]         w_blk_h;
    logic [2:0]         w_trad_sh;
    logic [PAGE_W-1:0]  w_page_ext;
    logic [SPARE_W-1:0] w_spare_new;

    assign w_g         = i_id.geometry_byte;
    assign w_p         = i_id.plane_ecc_byte;
    assign w_ecode     = w_p[6:4];
    assign w_redt      = {w_g[6], w_g[3:2]};
    assign w_blk3      = {w_g[7], w_g[5:4]};
    assign w_blk_h     = w_g[5:4] | {1'b0, w_g[7]};
    assign w_trad_sh   = 3'(w_g[2]) + 3'(w_g[1:0]);
    assign w_page_ext  = 15'd2048 << w_g[1:0];
    assign w_spare_new = spare_new(w_redt);

    // Per-format geometry
    always_comb begin
        o_geom.base_mb         = dev_mb(i_id.device_code);
        o_geom.ce_bypass       = 1'b0;
        o_geom.plane_count     = 4'd1 << w_p[3:2];
        o_geom.page_bytes      = w_page_ext;
        o_geom.ecc_chunk_bytes = 12'd512;
        o_geom.block_bytes     = BLOCK_W'({blk_kb_hb(w_blk3), 10'b0});
        o_geom.spare_bytes     = spare_bg(w_redt);
        o_geom.ecc_strength    = 6'd1;
        unique case (i_fmt)
            FMT_H: begin
                o_geom.block_bytes  = BLOCK_W'({blk_kb_h(w_blk_h), 10'b0});
                o_geom.spare_bytes  = spare_h(w_redt);
                o_geom.ecc_strength = ecc_h(w_ecode);
            end
            FMT_HB: begin
                o_geom.spare_bytes     = spare_hb(w_redt);
                o_geom.ecc_strength    = ecc_hb(w_ecode);
                o_geom.ecc_chunk_bytes = chunk_hb(w_ecode);
            end
            FMT_HB_BG: begin
                o_geom.ecc_strength    = ecc_bg(w_ecode);
                o_geom.ecc_chunk_bytes = (w_ecode >= 3'd5) ? 12'd1024 : 12'd512;
            end
            FMT_HC_AG: begin
                o_geom.ecc_strength    = ecc_ag(w_ecode);
                o_geom.ecc_chunk_bytes = (w_ecode >= 3'd6) ? 12'd1024 : 12'd512;
            end
            FMT_NEWSTY: begin
                o_geom.ce_bypass   = 1'b1;
                o_geom.block_bytes = 25'd131072 << w_blk3;
                // zero spare code falls back to 16 bytes per 512 of page
                o_geom.spare_bytes = (w_spare_new == '0) ? (10'd64 << w_g[1:0])
                                                         : w_spare_new;
                case (w_ecode)
                    3'd5: begin
                        o_geom.ecc_strength    = 6'd24;
                        o_geom.ecc_chunk_bytes = 12'd1024;
                    end
                    3'd6: begin
                        o_geom.ecc_strength    = 6'd40;
                        o_geom.ecc_chunk_bytes = 12'd1024;
                    end
                    3'd7: begin
                        o_geom.ecc_strength    = 6'd60;
                        o_geom.ecc_chunk_bytes = 12'd1024;
                    end
                    default: o_geom.ecc_strength = 6'd1 << w_ecode;
                endcase
            end
            default: begin
                // traditional rules, also for the unused format codes
                o_geom.page_bytes   = 15'd1024 << w_g[1:0];
                o_geom.spare_bytes  = 10'd16 << w_trad_sh;
                o_geom.block_bytes  = 25'd65536 << w_g[5:4];
                o_geom.ecc_strength = (i_id.cell_byte[3:2] != 2'b00) ? 6'd4 : 6'd1;
            end
        endcase
    end

endmodule

/* hw/rtl/nand_id_geometry_decoder.sv */
// NAND ID geometry decoder, top level: APB registers and three-stage item pipeline.
// Depends on nidg_pkg, nidg_decode and assert_macros.svh.
//
// Takes the four ID bytes after the maker byte and returns capacity, block,
// page and spare size, ECC strength and chunk size and plane count in one
// result item. One item is accepted every cycle while the output is not
// stalled; each item goes through three register stages (input capture, table
// decode, capacity scaling and output register) before its result appears.
// Registers: 0x0 id_format (3 bits, reset 0),
// 0x4 chip_enable_count (4 bits, reset 1); write them only while no item is in flight.
module nand_id_geometry_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // ID item input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] device_code, [15:8] cell_byte, [23:16] geometry_byte,
    // [31:24] plane_ecc_byte
    input  logic [31:0] s_axis_tdata,
    // geometry result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [16:0] capacity_mb, [41:17] block_bytes, [56:42] page_bytes,
    // [66:57] spare_bytes, [72:67] ecc_strength, [84:73] ecc_chunk_bytes,
    // [88:85] plane_count, [95:89] zero
    output logic [95:0] m_axis_tdata
);
    import nidg_pkg::*;

    `include "assert_macros.svh"

    localparam logic REG_ID_FORMAT = 1'b0;
    localparam logic REG_CE_COUNT  = 1'b1;

    // Configuration registers
    t_fmt            r_id_format;
    logic [CE_W-1:0] r_ce_count;
    logic            w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_format <= FMT_TRAD;
            r_ce_count  <= 4'd1;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_ID_FORMAT) begin
                r_id_format <= t_fmt'(pwdata[2:0]);
            end else begin
                r_ce_count <= pwdata[CE_W-1:0];
            end
        end
    end

    always_comb begin
        case (paddr[2])
            REG_CE_COUNT: prdata = {28'b0, r_ce_count};
            default:      prdata = {29'b0, r_id_format};
        endcase
    end

    // Stage handshake: a stage moves when it is empty or the next one moves
    logic w_rdy1;
    logic w_rdy2;
    logic w_rdy3;
    logic r_v1;
    logic r_v2;
    logic r_v3;

    assign w_rdy3        = !r_v3 || m_axis_tready;
    assign w_rdy2        = !r_v2 || w_rdy3;
    assign w_rdy1        = !r_v1 || w_rdy2;
    assign s_axis_tready = w_rdy1;
    assign m_axis_tvalid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Stage 1: capture ID bytes
    t_id r_id;

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && w_rdy1) begin
            r_id <= t_id'(s_axis_tdata);
        end
    end

    // Stage 2: table and rule-set decode
    t_geom w_geom;
    t_geom r_geom;

    nidg_decode u_decode (
        .i_fmt  (r_id_format),
        .i_id   (r_id),
        .o_geom (w_geom)
    );

    always_ff @(posedge i_clk) begin
        if (r_v1 && w_rdy2) begin
            r_geom <= w_geom;
        end
    end

    // Stage 3: scale capacity by chip-enable count (bypassed in FMT_NEWSTY), saturate, output register
    logic [CE_W-1:0]        w_ce_eff;
    logic [BASE_W+CE_W-1:0] w_prod;
    logic [CAP_W-1:0]       w_cap;
    logic [CAP_W-1:0]       r_cap;
    t_geom                  r_out;

    assign w_ce_eff = r_geom.ce_bypass ? 4'd1 : r_ce_count;
    assign w_prod   = (BASE_W + CE_W)'(r_geom.base_mb) * (BASE_W + CE_W)'(w_ce_eff);
    assign w_cap    = (w_prod > (BASE_W + CE_W)'(CAP_MAX)) ? CAP_MAX : w_prod[CAP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (r_v2 && w_rdy3) begin
            r_cap <= w_cap;
            r_out <= r_geom;
        end
    end

    assign m_axis_tdata = {7'b0, r_out.plane_count, r_out.ecc_chunk_bytes,
                           r_out.ecc_strength, r_out.spare_bytes, r_out.page_bytes,
                           r_out.block_bytes, r_cap};

    // Checks
    `NIDG_ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_v1, "accepted item did not reach stage 1")
    `NIDG_ASSERT_IMPL(a_cap_saturated, i_clk, i_rst_n, m_axis_tvalid, r_cap <= CAP_MAX, "capacity above saturation limit")
    `NIDG_ASSERT_IMPL(a_plane_onehot, i_clk, i_rst_n, m_axis_tvalid, $onehot(r_out.plane_count), "plane count not a power of two")
    `NIDG_ASSERT_IMPL(a_chunk_legal, i_clk, i_rst_n, m_axis_tvalid, r_out.ecc_chunk_bytes == 12'd512 || r_out.ecc_chunk_bytes == 12'd1024 || r_out.ecc_chunk_bytes == 12'd2048, "illegal ECC chunk size")

endmodule

/* sim/tb_nand_id_geometry_decoder.sv */
`timescale 1ns / 100ps
// Self-checking testbench of nand_id_geometry_decoder: predicts each geometry result item.
// Depends on nidg_pkg and the nand_id_geometry_decoder RTL.
module tb_nand_id_geometry_decoder;
    import nidg_pkg::*;

    // Register byte addresses
    localparam logic [2:0] ADDR_ID_FORMAT = 3'h0;
    localparam logic [2:0] ADDR_CE_COUNT  = 3'h4;

    // Format codes that the package leaves unnamed; they decode like FMT_TRAD
    localparam logic [2:0] FMT_RSVD6 = 3'd6;
    localparam logic [2:0] FMT_RSVD7 = 3'd7;

    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 34;
    localparam int FIXED_PHASES  = 12;
    localparam int RANDOM_PHASES = 2;

    // Device-code table and its capacities in MB
    localparam logic [7:0] DEV_CODES [9] = '{8'hf0, 8'hd1, 8'hf1, 8'hda, 8'hdc,
                                             8'hd3, 8'hd5, 8'hd7, 8'hd9};
    localparam int unsigned DEV_MB [9] = '{64, 128, 128, 256, 512, 1024, 2048, 4096, 8192};

    // Per-format lookup tables
    localparam int unsigned BLK_KB_H  [8] = '{128, 256, 512, 768, 128, 128, 128, 128};
    localparam int unsigned BLK_KB_HB [8] = '{128, 256, 512, 768, 1024, 2048, 128, 128};
    localparam int unsigned SPARE_H   [8] = '{128, 224, 128, 128, 128, 128, 128, 128};
    localparam int unsigned SPARE_HB  [8] = '{128, 224, 448, 128, 128, 128, 128, 128};
    localparam int unsigned SPARE_BG  [8] = '{128, 224, 448, 64, 32, 16, 640, 128};
    localparam int unsigned ECC_H     [8] = '{1, 2, 4, 8, 12, 16, 1, 1};
    localparam int unsigned ECC_HB    [8] = '{1, 2, 4, 8, 16, 24, 24, 24};
    localparam int unsigned CHUNK_HB  [8] = '{512, 512, 512, 512, 512, 2048, 1024, 1024};
    localparam int unsigned ECC_BG    [8] = '{1, 1, 2, 4, 8, 40, 32, 24};
    localparam int unsigned ECC_AG    [8] = '{1, 1, 2, 4, 8, 24, 32, 40};
    localparam int unsigned CHUNK_BG  [8] = '{512, 512, 512, 512, 512, 1024, 1024, 1024};
    localparam int unsigned CHUNK_AG  [8] = '{512, 512, 512, 512, 512, 512, 1024, 1024};
    localparam int unsigned SPARE_NEW [8] = '{0, 128, 218, 400, 436, 512, 640, 0};

    // Settings walked in order: every format, unused codes, chip-enable extremes
    localparam logic [2:0] PHASE_FMT [FIXED_PHASES] = '{
        FMT_H, FMT_HB, FMT_HB_BG, FMT_HC_AG, FMT_NEWSTY, FMT_TRAD,
        FMT_RSVD6, FMT_RSVD7, FMT_NEWSTY, FMT_TRAD, FMT_H, FMT_HB_BG};
    localparam logic [3:0] PHASE_CE [FIXED_PHASES] = '{
        4'd1, 4'd2, 4'd4, 4'd8, 4'd15, 4'd0, 4'd3, 4'd15, 4'd0, 4'd8, 4'd15, 4'd1};

    // Result item as packed on m_axis_tdata, lowest field last
    typedef struct packed {
        logic [6:0]         pad;
        logic [PLANE_W-1:0] plane_count;
        logic [CHUNK_W-1:0] ecc_chunk_bytes;
        logic [ECC_W-1:0]   ecc_strength;
        logic [SPARE_W-1:0] spare_bytes;
        logic [PAGE_W-1:0]  page_bytes;
        logic [BLOCK_W-1:0] block_bytes;
        logic [CAP_W-1:0]   capacity_mb;
    } t_geom_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // device_code, cell_byte, geometry_byte, plane_ecc_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;          // capacity_mb, block_bytes, page_bytes, spare_bytes,
                                        // ecc_strength, ecc_chunk_bytes, plane_count, zero

    nand_id_geometry_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow copy of the registers
    logic [2:0]  fmt_shadow = FMT_TRAD;
    logic [3:0]  ce_shadow  = 4'd1;

    t_id         id_pending [$];
    t_geom_out   geom_expected [$];
    int          id_gap_max = 0;
    int          out_stall_max = 0;
    int          id_gap = 0;
    int          out_stall = 0;
    int          idle_cycles = 0;
    int          error_count = 0;
    int          items_sent = 0;
    int          results_checked = 0;
    int          settings_seen = 1;
    logic        apb_done = 1'b0;

    always #5 i_clk = ~i_clk;

    // Geometry that the block must report for one set of ID bytes
    function automatic t_geom_out predict_geometry(t_id id, logic [2:0] fmt, logic [3:0] ce);
        t_geom_out   r;
        int unsigned base_mb, cap, page, block, spare, ecc, chunk;
        logic [7:0]  g, p;
        logic [2:0]  ecode, redt, blk3, blk_h;
        g = id.geometry_byte;
        p = id.plane_ecc_byte;
        base_mb = 0;
        for (int k = 0; k < 9; k++)
            if (id.device_code == DEV_CODES[k])
                base_mb = DEV_MB[k];
        cap   = base_mb * ce;
        ecode = p[6:4];
        redt  = {g[6], g[3:2]};
        blk3  = {g[7], g[5:4]};
        // bit 7 overlaps bit 4 in the older block index
        blk_h = {2'b00, g[7]} | {1'b0, g[5:4]};
        page  = 2048 << g[1:0];
        chunk = 512;
        case (fmt)
            FMT_H: begin
                block = BLK_KB_H[blk_h] * 1024;
                spare = SPARE_H[redt];
                ecc   = ECC_H[ecode];
            end
            FMT_HB: begin
                block = BLK_KB_HB[blk3] * 1024;
                spare = SPARE_HB[redt];
                ecc   = ECC_HB[ecode];
                chunk = CHUNK_HB[ecode];
            end
            FMT_HB_BG: begin
                block = BLK_KB_HB[blk3] * 1024;
                spare = SPARE_BG[redt];
                ecc   = ECC_BG[ecode];
                chunk = CHUNK_BG[ecode];
            end
            FMT_HC_AG: begin
                block = BLK_KB_HB[blk3] * 1024;
                spare = SPARE_BG[redt];
                ecc   = ECC_AG[ecode];
                chunk = CHUNK_AG[ecode];
            end
            FMT_NEWSTY: begin
                block = 131072 << blk3;
                spare = SPARE_NEW[redt];
                // unlisted spare code: 16 bytes per 512
                if (spare == 0)
                    spare = 16 * (page / 512);
                case (ecode)
                    3'd5: begin ecc = 24; chunk = 1024; end
                    3'd6: begin ecc = 40; chunk = 1024; end
                    3'd7: begin ecc = 60; chunk = 1024; end
                    default: ecc = 1 << ecode;
                endcase
                // no chip-enable scaling here
                cap = base_mb;
            end
            default: begin
                ecc   = (id.cell_byte[3:2] != 2'b00) ? 4 : 1;
                page  = 1024 << g[1:0];
                spare = (8 << g[2]) * (page / 512);
                block = 65536 << g[5:4];
            end
        endcase
        if (cap > CAP_MAX)
            cap = CAP_MAX;
        r.pad             = '0;
        r.capacity_mb     = CAP_W'(cap);
        r.block_bytes     = BLOCK_W'(block);
        r.page_bytes      = PAGE_W'(page);
        r.spare_bytes     = SPARE_W'(spare);
        r.ecc_strength    = ECC_W'(ecc);
        r.ecc_chunk_bytes = CHUNK_W'(chunk);
        r.plane_count     = PLANE_W'(1 << p[3:2]);
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Driver: presents queued ID items, with a random gap after each
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            id_gap <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (id_gap != 0) begin
                s_axis_tvalid <= 1'b0;
                id_gap <= id_gap - 1;
            end else if (id_pending.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= id_pending.pop_front();
                id_gap <= $urandom_range(0, id_gap_max);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stall after each result item
    always @(posedge i_clk) begin
        int n;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            out_stall <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                n = $urandom_range(0, out_stall_max);
            else
                n = out_stall;
            if (n != 0) begin
                m_axis_tready <= 1'b0;
                out_stall <= n - 1;
            end else begin
                m_axis_tready <= 1'b1;
                out_stall <= 0;
            end
        end
    end

    // Monitor: predict on input, compare on output
    always @(posedge i_clk) begin
        t_geom_out want, got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                geom_expected.push_back(predict_geometry(t_id'(s_axis_tdata),
                                                         fmt_shadow, ce_shadow));
                items_sent++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_geom_out'(m_axis_tdata);
                if (geom_expected.size() == 0) begin
                    $error("result item with no ID item outstanding: %h", m_axis_tdata);
                    error_count++;
                end else begin
                    want = geom_expected.pop_front();
                    check_field("capacity_mb", want.capacity_mb, got.capacity_mb);
                    check_field("block_bytes", want.block_bytes, got.block_bytes);
                    check_field("page_bytes", want.page_bytes, got.page_bytes);
                    check_field("spare_bytes", want.spare_bytes, got.spare_bytes);
                    check_field("ecc_strength", want.ecc_strength, got.ecc_strength);
                    check_field("ecc_chunk_bytes", want.ecc_chunk_bytes, got.ecc_chunk_bytes);
                    check_field("plane_count", want.plane_count, got.plane_count);
                    check_field("pad", want.pad, got.pad);
                    results_checked++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted ID item, taken result or register access
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || apb_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: %0d ID items still pending, %0d results outstanding",
                     id_pending.size(), geom_expected.size());
            $display("tb_nand_id_geometry_decoder: done, errors");
            $finish;
        end
    end

    // Write a register, then read it back
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        apb_done <= 1'b1;
        if (addr == ADDR_ID_FORMAT)
            fmt_shadow = value[2:0];
        else
            ce_shadow = value[3:0];
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        apb_done <= 1'b0;
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== value) begin
            $error("register at %h: expected %0d, got %0d", addr, value, prdata);
            error_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait until every queued item has gone in and every result has come out;
    // sampled on the falling edge so the handshakes of the last rising edge have settled
    task automatic wait_idle();
        @(negedge i_clk);
        while (id_pending.size() != 0 || s_axis_tvalid || geom_expected.size() != 0)
            @(negedge i_clk);
    endtask

    // Stimulus
    initial begin
        t_id        id;
        logic [2:0] fmt;
        logic [3:0] ce;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items under the reset settings
        id_gap_max = 3;
        out_stall_max = 3;
        id_pending.push_back('{8'h00, 8'h00, 8'h00, 8'h00});
        id_pending.push_back('{8'hff, 8'hff, 8'hff, 8'hff});
        for (int k = 0; k < 9; k++)
            id_pending.push_back('{8'(k * 8'h25), 8'(k * 8'h1d), 8'(k << 2), DEV_CODES[k]});
        id_pending.push_back('{8'h0c, 8'h03, 8'h04, 8'hd3});
        id_pending.push_back('{8'h70, 8'h34, 8'h08, 8'hd3});
        id_pending.push_back('{8'h8c, 8'hcb, 8'h0c, 8'hd9});
        id_pending.push_back('{8'hf3, 8'h30, 8'hf3, 8'hd9});
        id_pending.push_back('{8'h5c, 8'h0f, 8'hf0, 8'hee});
        id_pending.push_back('{8'h40, 8'h74, 8'h0c, 8'hd0});
        wait_idle();

        for (int ph = 0; ph < FIXED_PHASES + RANDOM_PHASES; ph++) begin
            if (ph < FIXED_PHASES) begin
                fmt = PHASE_FMT[ph];
                ce  = PHASE_CE[ph];
            end else begin
                fmt = $urandom_range(0, 7);
                ce  = $urandom_range(0, 15);
            end
            write_reg(ADDR_ID_FORMAT, {29'd0, fmt});
            write_reg(ADDR_CE_COUNT, {28'd0, ce});
            settings_seen++;

            // Idling pattern: both sides, none, sender only, receiver only
            case (ph % 4)
                0: begin id_gap_max = 3; out_stall_max = 3; end
                1: begin id_gap_max = 0; out_stall_max = 0; end
                2: begin id_gap_max = 3; out_stall_max = 0; end
                default: begin id_gap_max = 0; out_stall_max = 3; end
            endcase

            // Largest table entry with all fields high, and a table miss
            id_pending.push_back('{8'hff, 8'hff, 8'hff, 8'hd9});
            id_pending.push_back('{8'h00, 8'h00, 8'h00, 8'h00});
            for (int k = 0; k < RANDOM_ITEMS; k++) begin
                id = t_id'($urandom);
                // mostly known device codes so capacity scaling gets exercised
                if ($urandom_range(0, 3) != 0)
                    id.device_code = DEV_CODES[$urandom_range(0, 8)];
                id_pending.push_back(id);
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d ID items decoded and %0d result items checked", items_sent,
                 results_checked);
        $display("across %0d register settings: all formats, unused codes, chip-enable 0..15",
                 settings_seen);
        if (error_count == 0 && geom_expected.size() == 0)
            $display("tb_nand_id_geometry_decoder: done, clean");
        else
            $display("tb_nand_id_geometry_decoder: done, errors");
        $finish;
    end

endmodule
